/* hdl/mhtq_pkg.sv */
// ---------------------------------------------------------------------------
// Timer queue package
// Shared constants, operation and result codes, and sequencer states.
// ---------------------------------------------------------------------------
package mhtq_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_TIME_BITS   = 48;
    localparam int SLOTS           = 32;
    localparam int ID_W            = 5;
    localparam int IV_W            = 32;
    localparam int FIRE_CNT_W      = 6;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_EXPIRE   = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_INSERT_ACK = 2'd0,
        KIND_CANCEL_ACK = 2'd1,
        KIND_FIRED      = 2'd2,
        KIND_DONE       = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_ID_ACTIVE  = 2'd2,
        ST_ID_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MD_ACK,
        MD_EXP_REM,
        MD_EXP_PUSH
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REM,
        S_REM_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_RD1,
        S_DN_RD2,
        S_DN_CMP,
        S_EXP_CHK,
        S_EXP_RE,
        S_EMIT
    } state_t;

endpackage

/* hdl/mhtq_heap_ram.sv */
// ---------------------------------------------------------------------------
// Heap entry memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mhtq_heap_ram #(
    parameter int DEPTH = mhtq_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH = mhtq_pkg::DEF_TIME_BITS + mhtq_pkg::ID_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/min_heap_timer_queue_core.sv */
// ---------------------------------------------------------------------------
// Min-heap timer queue
// Binary min-heap of deadlines with per-id position map, insert, cancel by
// id and expire with restart of periodic timers.
// ---------------------------------------------------------------------------
// Usage: a command transaction (insert, cancel or expire) enters on the
// input channel while in_stall is low. Insert and cancel answer with one
// acknowledge; expire answers with one fired transaction per timer popped,
// then a done transaction. The last output of a command has last set.
// An insert sifts the new entry up; a removal moves the last entry into the
// hole, compares it first with its parent and sifts it up, or else down,
// all through one read port of the heap memory. An expire costs such a
// removal for every fired timer plus an insert for every restarted one.
// in_stall is high from acceptance until the last result is loaded into
// the output register; only one command is in flight at a time.
// The output register holds its transaction while out_stall is high and
// the sequencer waits for it to drain before producing the next one.
// Reset (rst_n low, asynchronous) empties the heap and marks every id
// inactive; no clearing pass is needed and a command may enter right after.
// Unknown operation codes are accepted and produce no output.
// ---------------------------------------------------------------------------
module min_heap_timer_queue_core #(
    parameter int QUEUE_DEPTH = mhtq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = mhtq_pkg::DEF_TIME_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic [mhtq_pkg::ID_W-1:0] timer_id,
    input  logic [TIME_BITS-1:0]     deadline,
    input  logic [mhtq_pkg::IV_W-1:0] interval,
    input  logic [TIME_BITS-1:0]     now_time,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               kind,
    output logic [1:0]               status,
    output logic [mhtq_pkg::ID_W-1:0] fired_id,
    output logic                     earliest_changed,
    output logic [TIME_BITS-1:0]     next_deadline,
    output logic                     queue_empty,
    output logic                     last
);

    localparam int ID_W  = mhtq_pkg::ID_W;
    localparam int IV_W  = mhtq_pkg::IV_W;
    localparam int NS    = mhtq_pkg::SLOTS;
    localparam int FW    = mhtq_pkg::FIRE_CNT_W;
    localparam int POS_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = POS_W + 2;
    localparam int EW    = TIME_BITS + ID_W;
    localparam int SUM_W = ((TIME_BITS > IV_W) ? TIME_BITS : IV_W) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    mhtq_pkg::state_t state_reg, state_next;
    mhtq_pkg::mode_t  mode_reg, mode_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NS-1:0]        active_reg;
    logic [POS_W-1:0]     pos_reg [NS];
    logic [IV_W-1:0]      ival_reg [NS];
    logic [ID_W-1:0]      fb_reg [NS];
    logic [TIME_BITS-1:0] top_dl_reg;
    logic [ID_W-1:0]      top_id_reg;
    logic [POS_W-1:0]     p_reg, p_next;
    logic [POS_W-1:0]     m_reg, m_next;
    logic [TIME_BITS-1:0] e_dl_reg, e_dl_next, c_dl_reg, c_dl_next, now_reg, now_next;
    logic [ID_W-1:0]      e_id_reg, e_id_next, c_id_reg, c_id_next;
    logic                 try_down_reg, try_down_next;
    logic [FW-1:0]        n_reg, n_next, i_reg, i_next;

    logic [1:0]           em_kind_reg, em_kind_next, em_status_reg, em_status_next;
    logic [ID_W-1:0]      em_id_reg, em_id_next;
    logic                 em_chg_reg, em_chg_next, em_last_reg, em_last_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, status_reg;
    logic [ID_W-1:0]      fired_id_reg;
    logic                 chg_reg, empty_reg, last_reg;
    logic [TIME_BITS-1:0] nd_reg;

    // Memory and small-array write controls.
    logic                 mem_we;
    logic [POS_W-1:0]     mem_waddr, mem_raddr;
    logic [EW-1:0]        mem_wdata, mem_rdata;
    logic                 pos_we, act_we, act_val, ival_we, fb_we;
    logic [ID_W-1:0]      pos_idx, act_idx, fb_idx;
    logic [POS_W-1:0]     pos_data;
    logic [ID_W-1:0]      fb_data;

    logic [TIME_BITS-1:0] rd_dl;
    logic [ID_W-1:0]      rd_id;
    assign rd_dl = mem_rdata[TIME_BITS-1:0];
    assign rd_id = mem_rdata[EW-1:TIME_BITS];

    // Sequencer conditions.
    logic                 in_acc, id_busy, full, rem_skip, rem_tail, up_root, up_move;
    logic                 dn_leaf, dn_two, dn_right, dn_stop, exp_fire, re_more, re_push;
    logic                 out_free;
    logic [CNT_W-1:0]     cnt_m1, p_ext;
    logic [CW-1:0]        c_idx, c1_idx;
    logic [POS_W-1:0]     parent;
    logic [ID_W-1:0]      re_t;
    logic [SUM_W-1:0]     re_sum;
    logic [TIME_BITS-1:0] re_dl;
    mhtq_pkg::state_t     after_state;

    assign in_stall = (state_reg != mhtq_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign id_busy  = active_reg[timer_id];
    assign full     = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign p_ext    = CNT_W'(p_reg);
    assign rem_skip = (count_reg == '0) || (p_ext >= count_reg);
    assign rem_tail = (p_ext == cnt_m1);
    assign up_root  = (p_reg == '0);
    assign parent   = POS_W'((p_reg - POS_W'(1)) >> 1);
    assign up_move  = (e_dl_reg < rd_dl);
    assign c_idx    = {1'b0, p_reg, 1'b1};
    assign c1_idx   = c_idx + CW'(1);
    assign dn_leaf  = (c_idx >= CW'(count_reg));
    assign dn_two   = (c1_idx < CW'(count_reg));
    assign dn_right = !(c_dl_reg < rd_dl);
    assign dn_stop  = (e_dl_reg < c_dl_reg);
    assign exp_fire = (count_reg != '0) && (n_reg < FW'(NS)) && (top_dl_reg <= now_reg);
    assign re_more  = (i_reg < n_reg);
    assign re_t     = fb_reg[i_reg[ID_W-1:0]];
    assign re_push  = (ival_reg[re_t] != '0) && !full;
    assign re_sum   = SUM_W'(now_reg) + SUM_W'(ival_reg[re_t]);
    assign re_dl    = (re_sum > SUM_W'(TMAX)) ? TMAX : re_sum[TIME_BITS-1:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign after_state = (mode_reg == mhtq_pkg::MD_EXP_PUSH) ? mhtq_pkg::S_EXP_RE
                                                             : mhtq_pkg::S_EMIT;

    mhtq_heap_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW),
        .AW    (POS_W)
    ) u_heap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhtq_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (operation)
                        mhtq_pkg::OP_INSERT:
                            state_next = (id_busy || full) ? mhtq_pkg::S_EMIT
                                                           : mhtq_pkg::S_UP_RD;
                        mhtq_pkg::OP_CANCEL:
                            state_next = id_busy ? mhtq_pkg::S_REM : mhtq_pkg::S_EMIT;
                        mhtq_pkg::OP_EXPIRE:
                            state_next = mhtq_pkg::S_EXP_CHK;
                        default:
                            state_next = mhtq_pkg::S_IDLE;
                    endcase
                end
            end
            mhtq_pkg::S_REM:
                state_next = (rem_skip || rem_tail) ? after_state : mhtq_pkg::S_REM_WAIT;
            mhtq_pkg::S_REM_WAIT:
                state_next = mhtq_pkg::S_UP_RD;
            mhtq_pkg::S_UP_RD:
            begin
                if (!up_root)
                    state_next = mhtq_pkg::S_UP_CMP;
                else
                    state_next = try_down_reg ? mhtq_pkg::S_DN_CHK : after_state;
            end
            mhtq_pkg::S_UP_CMP:
            begin
                if (up_move)
                    state_next = mhtq_pkg::S_UP_RD;
                else
                    state_next = try_down_reg ? mhtq_pkg::S_DN_CHK : after_state;
            end
            mhtq_pkg::S_DN_CHK:
                state_next = dn_leaf ? after_state : mhtq_pkg::S_DN_RD1;
            mhtq_pkg::S_DN_RD1:
                state_next = dn_two ? mhtq_pkg::S_DN_RD2 : mhtq_pkg::S_DN_CMP;
            mhtq_pkg::S_DN_RD2:
                state_next = mhtq_pkg::S_DN_CMP;
            mhtq_pkg::S_DN_CMP:
                state_next = dn_stop ? after_state : mhtq_pkg::S_DN_CHK;
            mhtq_pkg::S_EXP_CHK:
                state_next = exp_fire ? mhtq_pkg::S_REM : mhtq_pkg::S_EXP_RE;
            mhtq_pkg::S_EXP_RE:
            begin
                if (!re_more)
                    state_next = mhtq_pkg::S_EMIT;
                else if (re_push)
                    state_next = mhtq_pkg::S_UP_RD;
                else
                    state_next = mhtq_pkg::S_EXP_RE;
            end
            mhtq_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = em_last_reg ? mhtq_pkg::S_IDLE : mhtq_pkg::S_EXP_CHK;
            end
            default:
                state_next = mhtq_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        e_dl_next      = e_dl_reg;
        e_id_next      = e_id_reg;
        c_dl_next      = c_dl_reg;
        c_id_next      = c_id_reg;
        now_next       = now_reg;
        try_down_next  = try_down_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        em_kind_next   = em_kind_reg;
        em_status_next = em_status_reg;
        em_id_next     = em_id_reg;
        em_chg_next    = em_chg_reg;
        em_last_next   = em_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = p_reg;
        mem_wdata      = {e_id_reg, e_dl_reg};
        mem_raddr      = parent;
        pos_we         = 1'b0;
        pos_idx        = e_id_reg;
        pos_data       = p_reg;
        act_we         = 1'b0;
        act_idx        = timer_id;
        act_val        = 1'b0;
        ival_we        = 1'b0;
        fb_we          = 1'b0;
        fb_idx         = n_reg[ID_W-1:0];
        fb_data        = top_id_reg;

        unique case (state_reg)
            mhtq_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    now_next     = now_time;
                    em_id_next   = timer_id;
                    em_chg_next  = 1'b0;
                    em_last_next = 1'b1;
                    mode_next    = mhtq_pkg::MD_ACK;
                    unique case (operation)
                        mhtq_pkg::OP_INSERT:
                        begin
                            em_kind_next = mhtq_pkg::KIND_INSERT_ACK;
                            if (id_busy)
                                em_status_next = mhtq_pkg::ST_ID_ACTIVE;
                            else if (full)
                                em_status_next = mhtq_pkg::ST_FULL;
                            else
                            begin
                                em_status_next = mhtq_pkg::ST_OK;
                                em_chg_next    = (count_reg == '0) || (deadline < top_dl_reg);
                                ival_we        = 1'b1;
                                act_we         = 1'b1;
                                act_val        = 1'b1;
                                p_next         = count_reg[POS_W-1:0];
                                count_next     = count_reg + CNT_W'(1);
                                e_dl_next      = deadline;
                                e_id_next      = timer_id;
                                try_down_next  = 1'b0;
                            end
                        end
                        mhtq_pkg::OP_CANCEL:
                        begin
                            em_kind_next = mhtq_pkg::KIND_CANCEL_ACK;
                            if (!id_busy)
                                em_status_next = mhtq_pkg::ST_ID_MISSING;
                            else
                            begin
                                em_status_next = mhtq_pkg::ST_OK;
                                em_chg_next    = (pos_reg[timer_id] == '0);
                                act_we         = 1'b1;
                                act_val        = 1'b0;
                                p_next         = pos_reg[timer_id];
                            end
                        end
                        mhtq_pkg::OP_EXPIRE:
                        begin
                            n_next = '0;
                        end
                        default:
                        begin
                            n_next = n_reg;
                        end
                    endcase
                end
            end
            mhtq_pkg::S_REM:
            begin
                mem_raddr = cnt_m1[POS_W-1:0];
                if (!rem_skip)
                    count_next = cnt_m1;
            end
            mhtq_pkg::S_REM_WAIT:
            begin
                e_dl_next     = rd_dl;
                e_id_next     = rd_id;
                try_down_next = 1'b1;
            end
            mhtq_pkg::S_UP_RD:
            begin
                mem_raddr = parent;
                if (up_root && !try_down_reg)
                begin
                    mem_we = 1'b1;
                    pos_we = 1'b1;
                end
            end
            mhtq_pkg::S_UP_CMP:
            begin
                if (up_move)
                begin
                    // The parent drops into the hole and the hole climbs.
                    mem_we        = 1'b1;
                    mem_wdata     = mem_rdata;
                    pos_we        = 1'b1;
                    pos_idx       = rd_id;
                    p_next        = parent;
                    try_down_next = 1'b0;
                end
                else if (!try_down_reg)
                begin
                    mem_we = 1'b1;
                    pos_we = 1'b1;
                end
            end
            mhtq_pkg::S_DN_CHK:
            begin
                mem_raddr = c_idx[POS_W-1:0];
                if (dn_leaf)
                begin
                    mem_we = 1'b1;
                    pos_we = 1'b1;
                end
            end
            mhtq_pkg::S_DN_RD1:
            begin
                c_dl_next = rd_dl;
                c_id_next = rd_id;
                m_next    = c_idx[POS_W-1:0];
                mem_raddr = c1_idx[POS_W-1:0];
            end
            mhtq_pkg::S_DN_RD2:
            begin
                // Ties go to the right child.
                if (dn_right)
                begin
                    c_dl_next = rd_dl;
                    c_id_next = rd_id;
                    m_next    = c1_idx[POS_W-1:0];
                end
            end
            mhtq_pkg::S_DN_CMP:
            begin
                mem_we = 1'b1;
                pos_we = 1'b1;
                if (!dn_stop)
                begin
                    mem_wdata = {c_id_reg, c_dl_reg};
                    pos_idx   = c_id_reg;
                    p_next    = m_reg;
                end
            end
            mhtq_pkg::S_EXP_CHK:
            begin
                if (exp_fire)
                begin
                    fb_we          = 1'b1;
                    n_next         = n_reg + FW'(1);
                    act_we         = 1'b1;
                    act_idx        = top_id_reg;
                    act_val        = 1'b0;
                    p_next         = pos_reg[top_id_reg];
                    mode_next      = mhtq_pkg::MD_EXP_REM;
                    em_kind_next   = mhtq_pkg::KIND_FIRED;
                    em_status_next = mhtq_pkg::ST_OK;
                    em_id_next     = top_id_reg;
                    em_chg_next    = 1'b0;
                    em_last_next   = 1'b0;
                end
                else
                begin
                    i_next = '0;
                end
            end
            mhtq_pkg::S_EXP_RE:
            begin
                if (re_more)
                begin
                    i_next = i_reg + FW'(1);
                    if (re_push)
                    begin
                        act_we        = 1'b1;
                        act_idx       = re_t;
                        act_val       = 1'b1;
                        p_next        = count_reg[POS_W-1:0];
                        count_next    = count_reg + CNT_W'(1);
                        e_dl_next     = re_dl;
                        e_id_next     = re_t;
                        try_down_next = 1'b0;
                        mode_next     = mhtq_pkg::MD_EXP_PUSH;
                    end
                end
                else
                begin
                    em_kind_next   = mhtq_pkg::KIND_DONE;
                    em_status_next = mhtq_pkg::ST_OK;
                    em_id_next     = '0;
                    em_chg_next    = (n_reg != '0);
                    em_last_next   = 1'b1;
                end
            end
            mhtq_pkg::S_EMIT:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign out_valid_next = (state_reg == mhtq_pkg::S_EMIT && out_free) ? 1'b1 :
                            (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhtq_pkg::S_IDLE;
            mode_reg      <= mhtq_pkg::MD_ACK;
            count_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            try_down_reg  <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            try_down_reg  <= try_down_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            if (act_we)
                active_reg[act_idx] <= act_val;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        m_reg         <= m_next;
        e_dl_reg      <= e_dl_next;
        e_id_reg      <= e_id_next;
        c_dl_reg      <= c_dl_next;
        c_id_reg      <= c_id_next;
        now_reg       <= now_next;
        em_kind_reg   <= em_kind_next;
        em_status_reg <= em_status_next;
        em_id_reg     <= em_id_next;
        em_chg_reg    <= em_chg_next;
        em_last_reg   <= em_last_next;
        if (pos_we)
            pos_reg[pos_idx] <= pos_data;
        if (ival_we)
            ival_reg[timer_id] <= interval;
        if (fb_we)
            fb_reg[fb_idx] <= fb_data;
        // Shadow of the heap root for the alarm output and expire checks.
        if (mem_we && mem_waddr == '0)
        begin
            top_dl_reg <= mem_wdata[TIME_BITS-1:0];
            top_id_reg <= mem_wdata[EW-1:TIME_BITS];
        end
        if (state_reg == mhtq_pkg::S_EMIT && out_free)
        begin
            kind_reg     <= em_kind_reg;
            status_reg   <= em_status_reg;
            fired_id_reg <= em_id_reg;
            chg_reg      <= em_chg_reg;
            last_reg     <= em_last_reg;
            empty_reg    <= (count_reg == '0);
            nd_reg       <= (count_reg == '0) ? '0 : top_dl_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign status           = status_reg;
    assign fired_id         = fired_id_reg;
    assign earliest_changed = chg_reg;
    assign next_deadline    = nd_reg;
    assign queue_empty      = empty_reg;
    assign last             = last_reg;

endmodule
